>>> hdl/glos_pkg.sv
// Shared types, constants and helpers for the grid line-of-sight checker.
// No dependencies; the walker, the top level and the checker refer to this package.
package glos_pkg;

  localparam int unsigned GRID_COLS_DEF = 256;
  localparam int unsigned GRID_ROWS_DEF = 256;

  // Coordinate width is fixed by the item fields.
  localparam int unsigned COORD_W = 8;
  // Signed error term: spans roughly -2*dRow .. +2*dCol.
  localparam int unsigned ERR_W   = COORD_W + 3;

  // Item function codes.
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic signed [ERR_W-1:0] err_t;

  typedef enum logic [1:0] {
    W_IDLE,
    W_WALK,
    W_DRAIN,
    W_DONE
  } walk_state_e;

  // Walker status towards the top level.
  typedef struct packed {
    logic busy;
    logic done;
    logic blocked;
  } walk_stat_t;

  function automatic logic in_grid(coord_t col, coord_t row,
                                   int unsigned cols, int unsigned rows);
    return (32'(col) < cols) && (32'(row) < rows);
  endfunction

  // Linear map index, row-major.
  function automatic logic [31:0] cell_index(coord_t col, coord_t row, int unsigned cols);
    return 32'(row) * 32'(cols) + 32'(col);
  endfunction

endpackage

>>> hdl/glos_map_ram.sv
// One-bit occupancy map: single write port, single read port, registered read.
// Depends on nothing; depth follows the grid parameters of the top level.
module glos_map_ram #(
  parameter int unsigned DEPTH = 65536,
  parameter int unsigned AW    = 16
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic          wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic          rd_data_o
);

  logic mem_q [DEPTH];
  logic rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> hdl/glos_walker.sv
// Bresenham line walker: steps one cell a cycle, issues one map read per cell
// and folds the returned bits into a blocked flag. Uses glos_pkg.
module glos_walker #(
  parameter int unsigned GRID_COLS = glos_pkg::GRID_COLS_DEF,
  parameter int unsigned GRID_ROWS = glos_pkg::GRID_ROWS_DEF,
  parameter int unsigned AW        = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  glos_pkg::coord_t    col_a_i,
  input  glos_pkg::coord_t    row_a_i,
  input  glos_pkg::coord_t    col_b_i,
  input  glos_pkg::coord_t    row_b_i,
  input  logic                ack_i,
  output logic                rd_en_o,
  output logic [AW-1:0]       rd_addr_o,
  input  logic                rd_data_i,
  output glos_pkg::walk_stat_t stat_o
);

  glos_pkg::walk_state_e state_q, state_d;

  glos_pkg::coord_t col_q, col_d, row_q, row_d;
  glos_pkg::coord_t col_end_q, col_end_d, row_end_q, row_end_d;
  glos_pkg::coord_t dc_q, dc_d, dr_q, dr_d;
  logic             col_dec_q, col_dec_d, row_dec_q, row_dec_d;
  glos_pkg::err_t   err_q, err_d;
  logic             pend_q, pend_d;
  logic             blk_q, blk_d;

  logic             cur_oob, cur_last, blk_now;
  glos_pkg::err_t   dc2, dr2;
  glos_pkg::coord_t col_step, row_step;

  assign cur_oob  = !glos_pkg::in_grid(col_q, row_q, GRID_COLS, GRID_ROWS);
  assign cur_last = (col_q == col_end_q) && (row_q == row_end_q);
  assign blk_now  = blk_q | (pend_q & rd_data_i);
  assign dc2      = glos_pkg::err_t'({dc_q, 1'b0});
  assign dr2      = glos_pkg::err_t'({dr_q, 1'b0});
  assign col_step = col_dec_q ? col_q - 1'b1 : col_q + 1'b1;
  assign row_step = row_dec_q ? row_q - 1'b1 : row_q + 1'b1;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      glos_pkg::W_IDLE: begin
        if (start_i) state_d = glos_pkg::W_WALK;
      end
      glos_pkg::W_WALK: begin
        if (cur_last || cur_oob || blk_now) state_d = glos_pkg::W_DRAIN;
      end
      glos_pkg::W_DRAIN: state_d = glos_pkg::W_DONE;
      glos_pkg::W_DONE: begin
        if (ack_i) state_d = glos_pkg::W_IDLE;
      end
      default: state_d = glos_pkg::W_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    col_d     = col_q;
    row_d     = row_q;
    col_end_d = col_end_q;
    row_end_d = row_end_q;
    dc_d      = dc_q;
    dr_d      = dr_q;
    col_dec_d = col_dec_q;
    row_dec_d = row_dec_q;
    err_d     = err_q;
    pend_d    = 1'b0;
    blk_d     = blk_q;
    rd_en_o   = 1'b0;
    unique case (state_q)
      glos_pkg::W_IDLE: begin
        if (start_i) begin
          col_d     = col_a_i;
          row_d     = row_a_i;
          col_end_d = col_b_i;
          row_end_d = row_b_i;
          col_dec_d = col_b_i < col_a_i;
          row_dec_d = row_b_i < row_a_i;
          dc_d      = (col_b_i < col_a_i) ? col_a_i - col_b_i : col_b_i - col_a_i;
          dr_d      = (row_b_i < row_a_i) ? row_a_i - row_b_i : row_b_i - row_a_i;
          err_d     = glos_pkg::err_t'({1'b0, dc_d}) - glos_pkg::err_t'({1'b0, dr_d});
          blk_d     = 1'b0;
        end
      end
      glos_pkg::W_WALK: begin
        // Read the current cell; a cell off the grid counts as an obstacle.
        rd_en_o = !cur_oob;
        pend_d  = !cur_oob;
        blk_d   = blk_now | cur_oob;
        if (err_q > 0) begin
          col_d = col_step;
          err_d = err_q - dr2;
        end else if (err_q < 0) begin
          row_d = row_step;
          err_d = err_q + dc2;
        end else begin
          col_d = col_step;
          row_d = row_step;
          err_d = err_q + dc2 - dr2;
        end
      end
      glos_pkg::W_DRAIN: begin
        blk_d = blk_now;
      end
      glos_pkg::W_DONE: ;
      default: ;
    endcase
  end

  assign rd_addr_o      = AW'(glos_pkg::cell_index(col_q, row_q, GRID_COLS));
  assign stat_o.busy    = state_q != glos_pkg::W_IDLE;
  assign stat_o.done    = state_q == glos_pkg::W_DONE;
  assign stat_o.blocked = blk_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= glos_pkg::W_IDLE;
      pend_q  <= 1'b0;
      blk_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      blk_q   <= blk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    col_q     <= col_d;
    row_q     <= row_d;
    col_end_q <= col_end_d;
    row_end_q <= row_end_d;
    dc_q      <= dc_d;
    dr_q      <= dr_d;
    col_dec_q <= col_dec_d;
    row_dec_q <= row_dec_d;
    err_q     <= err_d;
  end

endmodule

>>> hdl/grid_line_of_sight_checker.sv
// Top level of the grid line-of-sight checker: item handshake, map write path,
// result register. Depends on glos_pkg, glos_map_ram and glos_walker.

// A write item (func 0) sets or clears one cell of a one-bit occupancy map held
// in a synchronous RAM of GRID_COLS*GRID_ROWS entries; it does not stall the input, gives
// no result, and a write off the grid is dropped. A query item (func 1) walks
// the line from (col_a, row_a) to (col_b, row_b) with a Bresenham stepper and
// gives one result item, clear = 1 when no cell on the line, ends included, is
// an obstacle. The walker reads one map cell per cycle, so a query holds the
// input stalled while its line is walked and until its result can enter the
// output register (a line covers at most 510 cells on a 256 by 256 grid); a
// result still stalled in the output register adds its wait on top. The
// walk ends early, in the cycle after the first obstacle is read, or on the
// first off-grid cell. One item is worked on at a time, but the next item is
// taken while a result still waits in the output register. Map contents are
// undefined after reset: write every cell a query may touch before querying it.
module grid_line_of_sight_checker #(
  parameter int unsigned GRID_COLS = glos_pkg::GRID_COLS_DEF,
  parameter int unsigned GRID_ROWS = glos_pkg::GRID_ROWS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             func_i,
  input  glos_pkg::coord_t col_a_i,
  input  glos_pkg::coord_t row_a_i,
  input  glos_pkg::coord_t col_b_i,
  input  glos_pkg::coord_t row_b_i,
  input  logic             obstacle_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             clear_o
);

  localparam int unsigned Depth = GRID_COLS * GRID_ROWS;
  localparam int unsigned AW    = (Depth > 2) ? $clog2(Depth) : 1;

  glos_pkg::walk_stat_t stat;
  logic                 in_accept;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic                 rd_data;
  logic                 out_free;
  logic                 out_load;
  logic                 out_valid_q, out_valid_d;
  logic                 clear_q, clear_d;

  // Hold the input while a query is walked and until its result is loaded.
  assign in_stall_o = stat.busy;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Write path: one map cell per write item, drop writes off the grid.
  assign wr_en   = in_accept && (func_i == glos_pkg::FUNC_WRITE) &&
                   glos_pkg::in_grid(col_a_i, row_a_i, GRID_COLS, GRID_ROWS);
  assign wr_addr = AW'(glos_pkg::cell_index(col_a_i, row_a_i, GRID_COLS));

  glos_map_ram #(
    .DEPTH (Depth),
    .AW    (AW)
  ) u_map (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (obstacle_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  glos_walker #(
    .GRID_COLS (GRID_COLS),
    .GRID_ROWS (GRID_ROWS),
    .AW        (AW)
  ) u_walker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (in_accept && (func_i == glos_pkg::FUNC_QUERY)),
    .col_a_i   (col_a_i),
    .row_a_i   (row_a_i),
    .col_b_i   (col_b_i),
    .row_b_i   (row_b_i),
    .ack_i     (out_free),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .rd_data_i (rd_data),
    .stat_o    (stat)
  );

  // Result register: the slot frees when empty or when taken this cycle.
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_load    = stat.done && out_free;
  assign out_valid_d = out_load || (out_valid_q && out_stall_i);
  assign clear_d     = out_load ? !stat.blocked : clear_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    clear_q <= clear_d;
  end

  assign out_valid_o = out_valid_q;
  assign clear_o     = clear_q;

endmodule

>>> hdl/glos_checker.sv
// Port-level assertions for the grid line-of-sight checker, bound to the top.
// Depends on glos_pkg for the function codes.
module glos_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic func_i,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic clear_o
);

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(clear_o))
    else $error("result changed while stalled");

  // An accepted query occupies the block on the next cycle.
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (func_i == glos_pkg::FUNC_QUERY) |=> in_stall_o)
    else $error("query accepted but block not busy");

  // A write item leaves the input open; it does not occupy the block.
  a_write_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (func_i == glos_pkg::FUNC_WRITE) |=> !in_stall_o)
    else $error("write item stalled the input");

  // A new result only appears at the end of a walk.
  a_result_from_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a query walk");

endmodule

bind grid_line_of_sight_checker glos_checker u_glos_checker (.*);
